// ----- design/assert_macros.svh -----
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/ahpf_pkg.sv -----
// ----------------------------------------------------------------------------
// ahpf_pkg
// Types, character codes and status codes of the audit header position finder.
// ----------------------------------------------------------------------------
package ahpf_pkg;

    localparam int TAG_LEN   = 10;
    localparam int TAG_CNT_W = 4;
    localparam int OUT_POS_W = 12;

    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_TAG   = 3'd1;
    localparam logic [2:0] ST_NO_CLOSE = 3'd2;
    localparam logic [2:0] ST_NO_DOT   = 3'd3;
    localparam logic [2:0] ST_NO_COLON = 3'd4;
    localparam logic [2:0] ST_TOO_LONG = 3'd5;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [OUT_POS_W-1:0] msg_start;
        logic [OUT_POS_W-1:0] secs_pos;
        logic [OUT_POS_W-1:0] nsecs_pos;
        logic [OUT_POS_W-1:0] id_pos;
        logic [OUT_POS_W-1:0] msg_end;
    } result_item_t;

    // input stage control seen by the scanner and the result stage
    typedef struct packed {
        logic valid;
        logic fire;
        logic last;
    } stage_ctl_t;

    // what the scanner knows about the line once its last byte is taken
    typedef struct packed {
        logic                 overflow;
        logic                 tag_found;
        logic                 close_found;
        logic                 dot_found;
        logic                 colon_ok;
        logic [OUT_POS_W-1:0] msg_start;
        logic [OUT_POS_W-1:0] secs_pos;
        logic [OUT_POS_W-1:0] nsecs_pos;
        logic [OUT_POS_W-1:0] id_pos;
        logic [OUT_POS_W-1:0] msg_end;
    } line_sum_t;

    // characters of the tag msg=audit(
    function automatic logic [7:0] tag_char(input logic [TAG_CNT_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h6D;
            4'd1:    ch = 8'h73;
            4'd2:    ch = 8'h67;
            4'd3:    ch = 8'h3D;
            4'd4:    ch = 8'h61;
            4'd5:    ch = 8'h75;
            4'd6:    ch = 8'h64;
            4'd7:    ch = 8'h69;
            4'd8:    ch = 8'h74;
            4'd9:    ch = 8'h28;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- design/audit_header_position_finder.sv -----
// One byte of a log line is taken per item, one item per clock unless held off; the result
// for a line is decoded as its last byte leaves the input register and is then held in the
// result register. The only hold-off is on a last byte while the result register still holds
// an untaken result, since each line yields exactly one result item. Positions count from
// zero, past MAX_LINE_LEN bytes the line is reported as too long, and all position fields
// carry the low 12 bits. On any error status the position fields are zero.
// ----------------------------------------------------------------------------
// audit_header_position_finder
// Finds the msg=audit( tag and the timestamp delimiters in a streamed log line.
// ----------------------------------------------------------------------------
module audit_header_position_finder #(
    parameter int MAX_LINE_LEN = 4096
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_stall,
    input  ahpf_pkg::char_item_t    char_item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output ahpf_pkg::result_item_t  result_item
);
    import ahpf_pkg::*;

    char_item_t s1_item;
    stage_ctl_t s1_ctl;
    line_sum_t  line_sum;
    logic       out_ready;

    ahpf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .out_ready  (out_ready),
        .item       (s1_item),
        .ctl        (s1_ctl)
    );

    ahpf_scan #(
        .MAX_LINE_LEN (MAX_LINE_LEN)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (s1_item),
        .ctl   (s1_ctl),
        .sum   (line_sum)
    );

    ahpf_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (s1_ctl),
        .sum          (line_sum),
        .out_ready    (out_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// ----- design/ahpf_in_stage.sv -----
// ----------------------------------------------------------------------------
// ahpf_in_stage
// Input register for one byte item and the handshake toward the sender.
// ----------------------------------------------------------------------------
module ahpf_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  ahpf_pkg::char_item_t  char_item,
    input  logic                  out_ready,
    output ahpf_pkg::char_item_t  item,
    output ahpf_pkg::stage_ctl_t  ctl
);
    import ahpf_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;
    logic       fire;
    logic       load;

    // only a last byte needs room in the result register
    assign fire       = valid_reg && (!item_reg.last_char || out_ready);
    assign char_stall = valid_reg && !fire;
    assign load       = char_valid && !char_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= char_item;
        end
    end

    assign item      = item_reg;
    assign ctl.valid = valid_reg;
    assign ctl.fire  = fire;
    assign ctl.last  = item_reg.last_char;

endmodule

// ----- design/ahpf_scan.sv -----
// ----------------------------------------------------------------------------
// ahpf_scan
// Per-line scanner: position counter, tag matcher and delimiter capture.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ahpf_scan #(
    parameter int MAX_LINE_LEN = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ahpf_pkg::char_item_t  item,
    input  ahpf_pkg::stage_ctl_t  ctl,
    output ahpf_pkg::line_sum_t   sum
);
    import ahpf_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE_LEN + 1);
    localparam int POS_W = $clog2(MAX_LINE_LEN);

    logic [CNT_W-1:0]     pos_reg,         pos_next,         upd_pos;
    logic [TAG_CNT_W-1:0] tag_cnt_reg,     tag_cnt_next,     upd_tag_cnt;
    logic                 tag_found_reg,   tag_found_next,   upd_tag_found;
    logic [POS_W-1:0]     tag_start_reg,   tag_start_next,   upd_tag_start;
    logic                 dot_found_reg,   dot_found_next,   upd_dot_found;
    logic [POS_W-1:0]     dot_pos_reg,     dot_pos_next,     upd_dot_pos;
    logic                 colon_found_reg, colon_found_next, upd_colon_found;
    logic [POS_W-1:0]     colon_pos_reg,   colon_pos_next,   upd_colon_pos;
    logic                 close_found_reg, close_found_next, upd_close_found;
    logic [POS_W-1:0]     close_pos_reg,   close_pos_next,   upd_close_pos;
    logic                 ovf_reg,         ovf_next,         upd_ovf;

    logic [POS_W-1:0]     pos_lo;
    logic                 tag_hit;
    logic [POS_W:0]       colon_after;

    assign pos_lo  = pos_reg[POS_W-1:0];
    assign tag_hit = (tag_cnt_reg < TAG_CNT_W'(TAG_LEN))
                     && (item.char_in == tag_char(tag_cnt_reg));

    always_comb
    begin
        upd_pos         = pos_reg;
        upd_tag_cnt     = tag_cnt_reg;
        upd_tag_found   = tag_found_reg;
        upd_tag_start   = tag_start_reg;
        upd_dot_found   = dot_found_reg;
        upd_dot_pos     = dot_pos_reg;
        upd_colon_found = colon_found_reg;
        upd_colon_pos   = colon_pos_reg;
        upd_close_found = close_found_reg;
        upd_close_pos   = close_pos_reg;
        upd_ovf         = ovf_reg;
        if (pos_reg >= CNT_W'(MAX_LINE_LEN))
        begin
            // past the bound only the last-byte mark matters
            upd_ovf = 1'b1;
        end
        else
        begin
            upd_pos = pos_reg + 1'b1;
            if (!tag_found_reg)
            begin
                if (tag_hit)
                begin
                    upd_tag_cnt = tag_cnt_reg + 1'b1;
                end
                else
                begin
                    // the tag holds one 'm', so a restart is at most one deep
                    upd_tag_cnt = (item.char_in == CHAR_M) ? TAG_CNT_W'(1) : '0;
                end
                if (upd_tag_cnt == TAG_CNT_W'(TAG_LEN))
                begin
                    upd_tag_found = 1'b1;
                    upd_tag_start = pos_lo - POS_W'(TAG_LEN - 1);
                end
            end
            else
            begin
                if (!close_found_reg && item.char_in == CHAR_CLOSE)
                begin
                    upd_close_found = 1'b1;
                    upd_close_pos   = pos_lo;
                end
                // colon counts only after a dot seen on an earlier byte
                if (dot_found_reg && !colon_found_reg && item.char_in == CHAR_COLON)
                begin
                    upd_colon_found = 1'b1;
                    upd_colon_pos   = pos_lo;
                end
                if (!dot_found_reg && item.char_in == CHAR_DOT)
                begin
                    upd_dot_found = 1'b1;
                    upd_dot_pos   = pos_lo;
                end
            end
        end
    end

    always_comb
    begin
        pos_next         = pos_reg;
        tag_cnt_next     = tag_cnt_reg;
        tag_found_next   = tag_found_reg;
        tag_start_next   = tag_start_reg;
        dot_found_next   = dot_found_reg;
        dot_pos_next     = dot_pos_reg;
        colon_found_next = colon_found_reg;
        colon_pos_next   = colon_pos_reg;
        close_found_next = close_found_reg;
        close_pos_next   = close_pos_reg;
        ovf_next         = ovf_reg;
        if (ctl.fire)
        begin
            if (ctl.last)
            begin
                // line done, start the next one clean
                pos_next         = '0;
                tag_cnt_next     = '0;
                tag_found_next   = 1'b0;
                tag_start_next   = '0;
                dot_found_next   = 1'b0;
                dot_pos_next     = '0;
                colon_found_next = 1'b0;
                colon_pos_next   = '0;
                close_found_next = 1'b0;
                close_pos_next   = '0;
                ovf_next         = 1'b0;
            end
            else
            begin
                pos_next         = upd_pos;
                tag_cnt_next     = upd_tag_cnt;
                tag_found_next   = upd_tag_found;
                tag_start_next   = upd_tag_start;
                dot_found_next   = upd_dot_found;
                dot_pos_next     = upd_dot_pos;
                colon_found_next = upd_colon_found;
                colon_pos_next   = upd_colon_pos;
                close_found_next = upd_close_found;
                close_pos_next   = upd_close_pos;
                ovf_next         = upd_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            tag_cnt_reg     <= '0;
            tag_found_reg   <= 1'b0;
            tag_start_reg   <= '0;
            dot_found_reg   <= 1'b0;
            dot_pos_reg     <= '0;
            colon_found_reg <= 1'b0;
            colon_pos_reg   <= '0;
            close_found_reg <= 1'b0;
            close_pos_reg   <= '0;
            ovf_reg         <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            tag_cnt_reg     <= tag_cnt_next;
            tag_found_reg   <= tag_found_next;
            tag_start_reg   <= tag_start_next;
            dot_found_reg   <= dot_found_next;
            dot_pos_reg     <= dot_pos_next;
            colon_found_reg <= colon_found_next;
            colon_pos_reg   <= colon_pos_next;
            close_found_reg <= close_found_next;
            close_pos_reg   <= close_pos_next;
            ovf_reg         <= ovf_next;
        end
    end

    // id must start strictly before the close paren
    assign colon_after = {1'b0, upd_colon_pos} + 1'b1;

    assign sum.overflow    = upd_ovf;
    assign sum.tag_found   = upd_tag_found;
    assign sum.close_found = upd_close_found;
    assign sum.dot_found   = upd_dot_found;
    assign sum.colon_ok    = upd_colon_found && (colon_after < {1'b0, upd_close_pos});
    assign sum.msg_start   = OUT_POS_W'(upd_tag_start);
    assign sum.secs_pos    = OUT_POS_W'(upd_tag_start) + OUT_POS_W'(TAG_LEN);
    assign sum.nsecs_pos   = OUT_POS_W'(upd_dot_pos) + 1'b1;
    assign sum.id_pos      = OUT_POS_W'(upd_colon_pos) + 1'b1;
    assign sum.msg_end     = OUT_POS_W'(upd_close_pos);

    `AST_IMPL(a_tag_cnt_bound, clk, rst_n, !tag_found_reg, tag_cnt_reg < TAG_CNT_W'(TAG_LEN))
    `AST_IMPL(a_colon_after_dot, clk, rst_n, colon_found_reg, dot_found_reg)
    `AST_IMPL(a_ctl_last, clk, rst_n, ctl.valid, ctl.last == item.last_char)
    `AST_NEXT(a_clear_on_last, clk, rst_n, ctl.fire && ctl.last,
              pos_reg == '0 && !tag_found_reg && !ovf_reg)

endmodule

// ----- design/ahpf_result.sv -----
// ----------------------------------------------------------------------------
// ahpf_result
// Status decode and the result register toward the receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ahpf_result (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ahpf_pkg::stage_ctl_t    ctl,
    input  ahpf_pkg::line_sum_t     sum,
    output logic                    out_ready,
    output logic                    result_valid,
    input  logic                    result_stall,
    output ahpf_pkg::result_item_t  result_item
);
    import ahpf_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    result_item_t item_reg;
    result_item_t item_next;
    logic         load;

    assign out_ready = !valid_reg || !result_stall;
    assign load      = ctl.fire && ctl.last;

    always_comb
    begin
        item_next = '0;
        if (sum.overflow)
        begin
            item_next.status = ST_TOO_LONG;
        end
        else if (!sum.tag_found)
        begin
            item_next.status = ST_NO_TAG;
        end
        else if (!sum.close_found)
        begin
            item_next.status = ST_NO_CLOSE;
        end
        else if (!sum.dot_found)
        begin
            item_next.status = ST_NO_DOT;
        end
        else if (!sum.colon_ok)
        begin
            item_next.status = ST_NO_COLON;
        end
        else
        begin
            item_next.status    = ST_OK;
            item_next.msg_start = sum.msg_start;
            item_next.secs_pos  = sum.secs_pos;
            item_next.nsecs_pos = sum.nsecs_pos;
            item_next.id_pos    = sum.id_pos;
            item_next.msg_end   = sum.msg_end;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

    `AST_IMPL(a_load_valid, clk, rst_n, load, ctl.valid)
    `AST_NEXT(a_load_shows, clk, rst_n, load, valid_reg)
    `AST_IMPL(a_error_zero, clk, rst_n, valid_reg && item_reg.status != ST_OK,
              item_reg.msg_start == '0 && item_reg.secs_pos == '0 &&
              item_reg.nsecs_pos == '0 && item_reg.id_pos == '0 && item_reg.msg_end == '0)
    `AST_IMPL(a_secs_offset, clk, rst_n, valid_reg && item_reg.status == ST_OK,
              item_reg.secs_pos == item_reg.msg_start + OUT_POS_W'(TAG_LEN))

endmodule

// ----- tb/tb_audit_header_position_finder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audit_header_position_finder
// Streams log lines one byte per item into the header position finder, predicts
// the tag and delimiter positions and the status of each line, and checks every
// result item against the oldest prediction. Directed lines cover the tag,
// paren, dot and colon statuses, tag restarts and zero bytes; random lines
// follow, mostly well-formed headers with random content, with random idling
// on both channels.
// ----------------------------------------------------------------------------
module tb_audit_header_position_finder;

    import ahpf_pkg::*;

    localparam int          MAX_LINE    = 4096;
    localparam int          RANDOM_ITEMS = 1350;
    localparam int          QUIET_LIMIT = 1000;
    localparam logic [79:0] TAG_TEXT    = "msg=audit(";

    typedef enum int {
        LINE_CLEAN,
        LINE_NO_TAG,
        LINE_NO_DOT,
        LINE_NO_COLON,
        LINE_NO_CLOSE,
        LINE_SWAPPED,
        LINE_NOISE
    } line_shape_t;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         char_valid   = 1'b0;
    logic         char_stall;
    char_item_t   char_item    = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result_item;

    bit           idle_on      = 1'b1;
    int           stall_left   = 0;
    int           quiet_cycles = 0;
    int           chars_sent   = 0;
    logic [7:0]   line_buf[$];

    function automatic logic [7:0] tag_byte(input int idx);
        return TAG_TEXT[79-8*idx -: 8];
    endfunction

    class line_scoreboard;
        logic [12:0]  line_pos;
        logic [3:0]   match_cnt;
        bit           tag_seen;
        bit           dot_seen;
        bit           colon_seen;
        bit           close_seen;
        bit           overflow;
        logic [12:0]  tag_at;
        logic [12:0]  dot_at;
        logic [12:0]  colon_at;
        logic [12:0]  close_at;
        result_item_t expected_q[$];
        int unsigned  fails;
        int unsigned  lines_done;

        function new();
            clear_line();
            fails      = 0;
            lines_done = 0;
        endfunction

        function void clear_line();
            line_pos   = '0;
            match_cnt  = '0;
            tag_seen   = 1'b0;
            dot_seen   = 1'b0;
            colon_seen = 1'b0;
            close_seen = 1'b0;
            overflow   = 1'b0;
            tag_at     = '0;
            dot_at     = '0;
            colon_at   = '0;
            close_at   = '0;
        endfunction

        function void note_char(input char_item_t it);
            result_item_t r;
            logic [2:0]   st;
            if (line_pos >= 13'(MAX_LINE)) begin
                // bytes past the bound are only checked for the last mark
                overflow = 1'b1;
            end
            else begin
                if (!tag_seen) begin
                    if (match_cnt < 4'(TAG_LEN) && it.char_in == tag_byte(int'(match_cnt)))
                        match_cnt = match_cnt + 4'd1;
                    else
                        match_cnt = (it.char_in == CHAR_M) ? 4'd1 : 4'd0;
                    if (match_cnt == 4'(TAG_LEN)) begin
                        tag_seen = 1'b1;
                        tag_at   = line_pos - 13'(TAG_LEN - 1);
                    end
                end
                else begin
                    if (!close_seen && it.char_in == CHAR_CLOSE) begin
                        close_seen = 1'b1;
                        close_at   = line_pos;
                    end
                    if (dot_seen && !colon_seen && it.char_in == CHAR_COLON) begin
                        colon_seen = 1'b1;
                        colon_at   = line_pos;
                    end
                    if (!dot_seen && it.char_in == CHAR_DOT) begin
                        dot_seen = 1'b1;
                        dot_at   = line_pos;
                    end
                end
                line_pos = line_pos + 13'd1;
            end
            if (it.last_char) begin
                if (overflow)
                    st = ST_TOO_LONG;
                else if (!tag_seen)
                    st = ST_NO_TAG;
                else if (!close_seen)
                    st = ST_NO_CLOSE;
                else if (!dot_seen)
                    st = ST_NO_DOT;
                else if (!colon_seen || !(colon_at + 13'd1 < close_at))
                    st = ST_NO_COLON;
                else
                    st = ST_OK;
                r        = '0;
                r.status = st;
                if (st == ST_OK) begin
                    r.msg_start = tag_at[11:0];
                    r.secs_pos  = 12'(tag_at + 13'(TAG_LEN));
                    r.nsecs_pos = 12'(dot_at + 13'd1);
                    r.id_pos    = 12'(colon_at + 13'd1);
                    r.msg_end   = close_at[11:0];
                end
                expected_q.push_back(r);
                clear_line();
            end
        endfunction

        task report_mismatch(input string what, input int got, input int want);
            $display("mismatch on line %0d: %s got %0d expected %0d",
                     lines_done, what, got, want);
            fails++;
        endtask

        task check_result(input result_item_t got);
            result_item_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing pending, status",
                                int'(got.status), 0);
            end
            else begin
                want = expected_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
                if (got.msg_start !== want.msg_start)
                    report_mismatch("msg_start", int'(got.msg_start), int'(want.msg_start));
                if (got.secs_pos !== want.secs_pos)
                    report_mismatch("secs_pos", int'(got.secs_pos), int'(want.secs_pos));
                if (got.nsecs_pos !== want.nsecs_pos)
                    report_mismatch("nsecs_pos", int'(got.nsecs_pos), int'(want.nsecs_pos));
                if (got.id_pos !== want.id_pos)
                    report_mismatch("id_pos", int'(got.id_pos), int'(want.id_pos));
                if (got.msg_end !== want.msg_end)
                    report_mismatch("msg_end", int'(got.msg_end), int'(want.msg_end));
            end
            lines_done++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    line_scoreboard sb = new();

    audit_header_position_finder #(
        .MAX_LINE_LEN (MAX_LINE)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_item    (char_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always #6 clk = ~clk;

    // receiver side: stall in bursts while idling is on
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 19);
        end
        result_stall <= (stall_left != 0);
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n && char_valid && !char_stall)
            sb.note_char(char_item);
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_item);
        if (!rst_n || (char_valid && !char_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("audit_header_position_finder regression: fail");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 11) == 0)
        begin
            gap = $urandom_range(1, 19);
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_item  <= '{char_in: c, last_char: last};
        do
            @(posedge clk);
        while (!(char_valid && !char_stall));
        chars_sent++;
    endtask

    task automatic send_line();
        int n;
        n = line_buf.size();
        for (int i = 0; i < n; i++)
            send_char(line_buf[i], i == n - 1);
        line_buf.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_line();
    endtask

    // heavy noise leans on tag characters and delimiters
    task automatic push_noise(input int n, input bit heavy);
        int k;
        for (int i = 0; i < n; i++)
        begin
            if (heavy && $urandom_range(0, 1) == 0)
            begin
                k = $urandom_range(0, 12);
                if (k < TAG_LEN)
                    line_buf.push_back(tag_byte(k));
                else if (k == TAG_LEN)
                    line_buf.push_back(CHAR_CLOSE);
                else if (k == TAG_LEN + 1)
                    line_buf.push_back(CHAR_DOT);
                else
                    line_buf.push_back(CHAR_COLON);
            end
            else
            begin
                line_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                push_noise(1, 1'b1);
            else
                line_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic push_tag();
        for (int i = 0; i < TAG_LEN; i++)
            line_buf.push_back(tag_byte(i));
    endtask

    task automatic send_random_line(input line_shape_t shape);
        int part;
        if (shape == LINE_NOISE)
        begin
            push_noise($urandom_range(1, 24), 1'($urandom_range(0, 1)));
            send_line();
            return;
        end
        push_noise($urandom_range(0, 6), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
        begin
            // partial tag that breaks off, ahead of the real one where the shape has one
            part = $urandom_range(1, TAG_LEN - 1);
            for (int i = 0; i < part; i++)
                line_buf.push_back(tag_byte(i));
        end
        if (shape != LINE_NO_TAG)
            push_tag();
        push_digits($urandom_range(0, 10));
        if (shape == LINE_SWAPPED)
        begin
            line_buf.push_back(CHAR_COLON);
            push_digits($urandom_range(0, 9));
            line_buf.push_back(CHAR_DOT);
        end
        else
        begin
            if (shape != LINE_NO_DOT)
                line_buf.push_back(CHAR_DOT);
            push_digits($urandom_range(0, 9));
            if (shape != LINE_NO_COLON)
                line_buf.push_back(CHAR_COLON);
        end
        push_digits($urandom_range(0, 5));
        if (shape != LINE_NO_CLOSE)
            line_buf.push_back(CHAR_CLOSE);
        push_noise($urandom_range(0, 6), 1'($urandom_range(0, 1)));
        send_line();
    endtask

    initial
    begin
        int          start_count;
        int          pick;
        line_shape_t shape;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte lines
        line_buf.push_back(8'h00);
        send_line();
        line_buf.push_back(8'hFF);
        send_line();
        send_text("msg=audit(1.2:3)");
        send_text("msg=audit(");
        send_text("msg=audit(12)");
        send_text("msg=audit(1.2)");
        // colon right before the close paren
        send_text("msg=audit(1.2:)");
        send_text("msg=audit(1:2.3)");
        send_text("mmsg=audit(1.2:3)");
        send_text("msg=amsg=audit(1.2:3)");
        send_text("msg=audit(msg=audit(1.2:3)");
        send_text(")msg=audit(1.2:3)");
        send_text("msg=audit()1.2:3)");
        send_text("msg=audit(1..2::3))");
        line_buf.push_back(8'h00);
        push_text("msg=audit(1");
        line_buf.push_back(8'h00);
        push_text(".2:3)");
        line_buf.push_back(8'h00);
        send_line();

        start_count = chars_sent;
        while (chars_sent - start_count < RANDOM_ITEMS)
        begin
            if (chars_sent - start_count > RANDOM_ITEMS * 85 / 100)
                idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                shape = LINE_CLEAN;
            else if (pick < 62)
                shape = LINE_NO_TAG;
            else if (pick < 69)
                shape = LINE_NO_DOT;
            else if (pick < 76)
                shape = LINE_NO_COLON;
            else if (pick < 83)
                shape = LINE_NO_CLOSE;
            else if (pick < 90)
                shape = LINE_SWAPPED;
            else
                shape = LINE_NOISE;
            send_random_line(shape);
        end
        idle_on = 1'b0;
        char_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.fails == 0)
            $display("audit_header_position_finder regression: pass");
        else
            $display("audit_header_position_finder regression: fail");
        $finish;
    end

endmodule

// ----- audit_header_position_finder.f -----
+incdir+design
design/ahpf_pkg.sv
design/ahpf_in_stage.sv
design/ahpf_scan.sv
design/ahpf_result.sv
design/audit_header_position_finder.sv
tb/tb_audit_header_position_finder.sv
